FILE: sv/tcw_pkg.sv
package tcw_pkg;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLANK_ATTR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAB_SHIFT  = 2'd2;

    localparam logic [7:0] RESET_ATTR      = 8'h0F;
    localparam logic [2:0] RESET_TAB_SHIFT = 3'd3;

    // column scratch width: last column plus the widest tab step
    localparam int COLX_W = 8;

    typedef struct packed {
        logic load;
        logic put;
        logic home;
        logic rd_first;
        logic copy;
        logic fill;
        logic init;
        logic rd_cell;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scroll;
        logic copy_last;
        logic fill_last;
    } sts_t;

endpackage

FILE: sv/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tcw_ctrl.sv
module tcw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [1:0]    op,
    input  tcw_pkg::sts_t sts,
    output tcw_pkg::cmd_t cmd,
    output logic          busy
);

    import tcw_pkg::*;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT,
        ST_CLEAR,
        ST_RD_FIRST,
        ST_COPY,
        ST_FILL,
        ST_READ,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.fill = 1'b1;
                cmd.init = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (op)
                        OP_PUT:   state_next = ST_PUT;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_READ:  state_next = ST_READ;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = sts.scroll ? ST_RD_FIRST : ST_FINISH;
            end
            ST_CLEAR:
            begin
                cmd.home   = 1'b1;
                state_next = ST_FILL;
            end
            ST_RD_FIRST:
            begin
                cmd.rd_first = 1'b1;
                state_next   = ST_COPY;
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (sts.copy_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_READ:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

FILE: sv/tcw_dp.sv
module tcw_dp #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tcw_pkg::cmd_t                  cmd,
    output tcw_pkg::sts_t                  sts,
    input  logic [1:0]                     op,
    input  logic [7:0]                     char_code,
    input  logic [10:0]                    cell_index,
    input  logic                           wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [7:0]                     wr_data,
    output logic                           done,
    output logic [10:0]                    cursor_pos,
    output logic [15:0]                    cell_data
);

    import tcw_pkg::*;

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP   = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] COPY_AHEAD = ADDR_W'(COLS + 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
    localparam logic [COLX_W-1:0] COLS_X     = COLX_W'(COLS);
    localparam logic [COLX_W-1:0] LAST_COL_X = COLX_W'(COLS - 1);

    logic [7:0]        text_attr_reg;
    logic [7:0]        blank_attr_reg;
    logic [2:0]        tab_shift_reg;
    logic [7:0]        char_reg;
    logic [10:0]       index_reg;
    logic              rd_ok_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              done_reg;
    logic [10:0]       pos_reg;
    logic [15:0]       data_reg;

    logic [COLX_W-1:0] col_ext;
    logic [COLX_W-1:0] tab_w;
    logic [COLX_W-1:0] col_x;
    logic [ROW_W-1:0]  row_b;
    logic              adv;
    logic              wr_char;
    logic              scroll;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_next;
    logic [ADDR_W-1:0] cur_pos;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [15:0]       ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    // cursor update for one character
    always_comb
    begin
        col_ext = COLX_W'(col_reg);
        tab_w   = COLX_W'(1) << tab_shift_reg;
        col_x   = col_ext;
        row_b   = row_reg;
        adv     = 1'b0;
        wr_char = 1'b0;
        case (char_reg)
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    col_x = col_ext - 1'b1;
                end
                else if (row_reg != '0)
                begin
                    row_b = row_reg - 1'b1;
                    col_x = LAST_COL_X;
                end
            end
            CH_TAB:
            begin
                col_x = (col_ext + tab_w) & ~(tab_w - 1'b1);
            end
            CH_CR:
            begin
                col_x = '0;
            end
            CH_LF:
            begin
                col_x = '0;
                adv   = 1'b1;
            end
            default:
            begin
                if (char_reg >= CH_SPACE)
                begin
                    wr_char = 1'b1;
                    col_x   = col_ext + 1'b1;
                end
            end
        endcase
        // line wrap
        if (col_x >= COLS_X)
        begin
            col_x = '0;
            adv   = 1'b1;
        end
        col_next = COL_W'(col_x);
        scroll   = adv && (row_reg == LAST_ROW);
        if (adv)
        begin
            row_next = scroll ? row_reg : row_reg + 1'b1;
        end
        else
        begin
            row_next = row_b;
        end
    end

    assign cur_pos = ADDR_W'(row_reg) * ROW_STEP + ADDR_W'(col_reg);

    assign sts.scroll    = scroll;
    assign sts.copy_last = (sweep_reg == COPY_LAST);
    assign sts.fill_last = (sweep_reg == LAST_CELL);

    // frame store port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = sweep_reg;
        ram_wdata = {blank_attr_reg, CH_SPACE};
        ram_re    = 1'b0;
        ram_raddr = sweep_reg + COPY_AHEAD;
        if (cmd.put && wr_char)
        begin
            ram_we    = 1'b1;
            ram_waddr = cur_pos;
            ram_wdata = {text_attr_reg, char_reg};
        end
        if (cmd.fill)
        begin
            ram_we = 1'b1;
            if (cmd.init)
            begin
                ram_wdata = {RESET_ATTR, CH_SPACE};
            end
        end
        if (cmd.copy)
        begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            ram_re    = !sts.copy_last;
        end
        if (cmd.rd_first)
        begin
            ram_re    = 1'b1;
            ram_raddr = ROW_STEP;
        end
        if (cmd.rd_cell)
        begin
            ram_re    = rd_ok_reg;
            ram_raddr = ADDR_W'(index_reg);
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attr_reg  <= RESET_ATTR;
            blank_attr_reg <= RESET_ATTR;
            tab_shift_reg  <= RESET_TAB_SHIFT;
            col_reg        <= '0;
            row_reg        <= '0;
            sweep_reg      <= '0;
            rd_ok_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_TEXT_ATTR:  text_attr_reg  <= wr_data;
                    REG_BLANK_ATTR: blank_attr_reg <= wr_data;
                    REG_TAB_SHIFT:  tab_shift_reg  <= wr_data[2:0];
                    default:        ;
                endcase
            end
            if (cmd.load)
            begin
                rd_ok_reg <= (op == OP_READ) && (32'(cell_index) < CELLS);
            end
            if (cmd.home)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.put)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cmd.home || cmd.rd_first)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.copy || cmd.fill)
            begin
                sweep_reg <= sts.fill_last ? '0 : sweep_reg + 1'b1;
            end
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg  <= char_code;
            index_reg <= cell_index;
        end
        if (cmd.finish)
        begin
            pos_reg  <= 11'(cur_pos);
            data_reg <= rd_ok_reg ? ram_rdata : 16'h0000;
        end
    end

    assign done       = done_reg;
    assign cursor_pos = pos_reg;
    assign cell_data  = data_reg;

endmodule

FILE: sv/text_console_writer.sv
// put char without scroll runs the put and finish states, read cell the read and finish
// states and the unused op finish only; a scrolling put char also moves the rows up
// and blanks the bottom row, and clear screen homes and blanks every cell, by the
// one-cell-a-cycle sweep of the frame RAM port; a new request may start at done
// reset: cursor homes and the frame is swept blank with busy high
// done is a one-cycle strobe; the receiver cannot stall
module text_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     op,
    input  logic [7:0]                     char_code,
    input  logic [10:0]                    cell_index,
    output logic                           done,
    output logic [10:0]                    cursor_pos,
    output logic [15:0]                    cell_data,
    input  logic                           wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [7:0]                     wr_data
);

    import tcw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    tcw_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .done       (done),
        .cursor_pos (cursor_pos),
        .cell_data  (cell_data)
    );

endmodule

FILE: sim/tb_text_console_writer.sv
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int COLS = 80;
    localparam int ROWS = 25;
    localparam int CELLS = COLS * ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [10:0] pos;
        logic [15:0] data;
    } console_result_t;

    class console_scoreboard;
        logic [15:0]     frame [CELLS];
        int unsigned     col;
        int unsigned     row;
        logic [7:0]      text_attr;
        logic [7:0]      blank_attr;
        logic [2:0]      tab_shift;
        console_result_t expected_q [$];
        int              errors;

        function new();
            text_attr = RESET_ATTR;
            blank_attr = RESET_ATTR;
            tab_shift = RESET_TAB_SHIFT;
            errors = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            for (int i = 0; i < CELLS; i++)
                frame[i] = {blank_attr, CH_SPACE};
            col = 0;
            row = 0;
        endfunction

        function void put_char(logic [7:0] c);
            int unsigned w;
            if (c == CH_BS) begin
                if (col > 0)
                    col--;
                else if (row > 0) begin
                    row--;
                    col = COLS - 1;
                end
            end else if (c == CH_TAB) begin
                w = 1 << tab_shift;
                col = (col + w) & ~(w - 1);
            end else if (c == CH_CR) begin
                col = 0;
            end else if (c == CH_LF) begin
                col = 0;
                row++;
            end else if (c >= CH_SPACE) begin
                frame[row * COLS + col] = {text_attr, c};
                col++;
            end
            if (col >= COLS) begin
                col = 0;
                row++;
            end
            // scroll up one line, new bottom row blank
            if (row >= ROWS) begin
                for (int i = 0; i < CELLS - COLS; i++)
                    frame[i] = frame[i + COLS];
                for (int i = CELLS - COLS; i < CELLS; i++)
                    frame[i] = {blank_attr, CH_SPACE};
                row = ROWS - 1;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] d);
            case (idx)
                REG_TEXT_ATTR:  text_attr = d;
                REG_BLANK_ATTR: blank_attr = d;
                REG_TAB_SHIFT:  tab_shift = d[2:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic [1:0] o, logic [7:0] c, logic [10:0] x);
            console_result_t e;
            e.op = o;
            e.data = '0;
            case (o)
                OP_PUT:   put_char(c);
                OP_CLEAR: clear_frame();
                OP_READ:  if (x < CELLS) e.data = frame[x];
                default: ;
            endcase
            e.pos = 11'(row * COLS + col);
            expected_q.push_back(e);
        endfunction

        function void check_result(logic [10:0] pos, logic [15:0] data);
            console_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: pos %0d data %h", pos, data);
                return;
            end
            e = expected_q.pop_front();
            if (pos !== e.pos || data !== e.data) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch op %0d: expected pos %0d data %h, got pos %0d data %h",
                             e.op, e.pos, e.data, pos, data);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           op;
    logic [7:0]           char_code;
    logic [10:0]          cell_index;
    logic                 done;
    logic [10:0]          cursor_pos;
    logic [15:0]          cell_data;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [7:0]           wr_data;

    console_scoreboard sb;
    int                stall_cycles = 0;

    text_console_writer #(
        .COLS(COLS),
        .ROWS(ROWS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .op         (op),
        .char_code  (char_code),
        .cell_index (cell_index),
        .done       (done),
        .cursor_pos (cursor_pos),
        .cell_data  (cell_data),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(cursor_pos, cell_data);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("** text_console_writer: FAILED **");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic issue(input logic [1:0] o, input logic [7:0] c, input logic [10:0] x);
        start <= 1'b1;
        op <= o;
        char_code <= c;
        cell_index <= x;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(o, c, x);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0 || busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= d;
        @(negedge clk);
        wr_en <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    task automatic pick_request(output logic [1:0] o, output logic [7:0] c,
                                output logic [10:0] x);
        int unsigned r;
        int unsigned s;
        r = $urandom_range(0, 999);
        s = $urandom_range(0, 9);
        o = OP_PUT;
        c = 8'($urandom);
        x = 11'($urandom);
        if (r < 700)
            c = 8'($urandom_range(32, 255));
        else if (r < 760)
            c = CH_LF;
        else if (r < 800)
            c = CH_CR;
        else if (r < 840)
            c = CH_BS;
        else if (r < 880)
            c = CH_TAB;
        else if (r < 900)
            c = 8'($urandom_range(0, 31));
        else if (r < 985) begin
            o = OP_READ;
            if (s < 5)
                x = 11'($urandom_range(0, CELLS - 1));
            else if (s < 8)
                x = 11'(sb.row * COLS + $urandom_range(0, COLS - 1));
            else
                x = 11'($urandom_range(CELLS, 2047));
        end else if (r < 995)
            o = OP_CLEAR;
        else
            o = OP_UNUSED;
    endtask

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial
    begin
        logic [1:0]  o;
        logic [7:0]  c;
        logic [10:0] x;
        logic [7:0]  ta;
        logic [7:0]  ba;
        logic [2:0]  ts;
        int          gap;

        sb = new();
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_PUT;
        char_code = '0;
        cell_index = '0;
        wr_en = 1'b0;
        wr_index = REG_TEXT_ATTR;
        wr_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // reset contents, edges of the index range
        issue(OP_READ, 8'h00, 11'd0);
        issue(OP_READ, 8'hFF, 11'(CELLS - 1));
        issue(OP_READ, 8'h00, 11'(CELLS));
        issue(OP_READ, 8'hFF, 11'h7FF);
        issue(OP_PUT, 8'h41, 11'd0);
        issue(OP_PUT, 8'hFF, 11'h7FF);
        issue(OP_PUT, CH_SPACE, 11'd0);
        issue(OP_PUT, 8'h1F, 11'd0);
        issue(OP_PUT, 8'h00, 11'd0);
        issue(OP_READ, 8'h00, 11'd0);
        issue(OP_READ, 8'h00, 11'd1);
        issue(OP_PUT, CH_BS, 11'd0);
        issue(OP_PUT, CH_CR, 11'd0);
        // backspace at the origin, then at column 0 of a lower row
        issue(OP_PUT, CH_BS, 11'd0);
        issue(OP_PUT, CH_LF, 11'd0);
        issue(OP_PUT, CH_BS, 11'd0);
        issue(OP_PUT, CH_TAB, 11'd0);
        issue(OP_PUT, CH_TAB, 11'd0);
        issue(OP_UNUSED, 8'hFF, 11'h7FF);
        issue(OP_CLEAR, 8'hAA, 11'h555);
        issue(OP_READ, 8'h55, 11'd0);
        issue(OP_READ, 8'h00, 11'd2);

        for (int p = 1; p <= 8; p++)
        begin
            wait_idle();
            ta = 8'($urandom);
            ba = 8'($urandom);
            ts = 3'($urandom_range(0, 7));
            if (p == 1) begin
                ta = 8'h00;
                ba = 8'hFF;
                ts = 3'd0;
            end else if (p == 2) begin
                ta = 8'hFF;
                ba = 8'h00;
                ts = 3'd7;
            end else if (p == 3)
                ts = 3'd6;
            write_reg(REG_TEXT_ATTR, ta);
            write_reg(REG_BLANK_ATTR, ba);
            write_reg(REG_TAB_SHIFT, {5'($urandom), ts});
            for (int n = 0; n < 160; n++)
            begin
                gap = (p % 3 == 0) ? 0 : pick_gap();
                if (gap > 0) begin
                    start <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
                pick_request(o, c, x);
                issue(o, c, x);
            end
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** text_console_writer: PASSED **");
        else
            $display("** text_console_writer: FAILED **");
        $finish;
    end

endmodule

FILE: sim.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/tcw_dp.sv
sv/text_console_writer.sv
sim/tb_text_console_writer.sv
